// ----- hdl/mafilt_pkg.sv -----
// Shared constants and width helpers for the moving average filter.
// No dependencies; the window, divider and top level files refer to this package.
package mafilt_pkg;

    // Width of one slice of the window sum fed to a partial-product multiplier.
    localparam int CHUNK_BITS = 16;

    // Bits needed to address a ring of the given depth (at least one).
    function automatic int ptr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Signed width that holds the sum of depth samples of the given width.
    function automatic int sum_width(input int depth, input int sample_bits);
        return sample_bits + $clog2(depth);
    endfunction

endpackage

// ----- hdl/mafilt_if.sv -----
// Valid/ready stream interfaces for the sample and average channels.
// No dependencies; used by the top level of the moving average filter.
interface mafilt_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface mafilt_average_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink (input valid, input average, output ready);
endinterface

// ----- hdl/mafilt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module mafilt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/mafilt_window.sv -----
// Window unit: ring of samples in RAM, running sum, oldest-slot pointer and first-word fill.
// Depends on mafilt_pkg and mafilt_ram.
module mafilt_window #(
    parameter int DEPTH       = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                                           clk,
    input  logic                                                           rst_n,
    input  logic                                                           in_valid,
    output logic                                                           in_ready,
    input  logic signed [SAMPLE_BITS-1:0]                                  in_sample,
    output logic                                                           out_valid,
    input  logic                                                           out_ready,
    output logic signed [mafilt_pkg::sum_width(DEPTH, SAMPLE_BITS)-1:0]    out_sum
);

    localparam int PTR_BITS = mafilt_pkg::ptr_width(DEPTH);
    localparam int SUM_BITS = mafilt_pkg::sum_width(DEPTH, SAMPLE_BITS);
    localparam logic signed [SUM_BITS-1:0] DEPTH_W = SUM_BITS'(DEPTH);
    localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(DEPTH - 1);

    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                          s1_hit_reg;
    logic signed [SAMPLE_BITS-1:0] s1_fwd_reg;
    logic                          fill_pending_reg;
    logic                          wrapped_reg;
    logic [PTR_BITS-1:0]           slot_reg;
    logic [PTR_BITS-1:0]           slot_next;
    logic signed [SAMPLE_BITS-1:0] seed_reg;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic signed [SUM_BITS-1:0]    sum_next;
    logic                          out_valid_reg;
    logic signed [SUM_BITS-1:0]    out_sum_reg;

    logic                          commit;
    logic                          accept;
    logic                          mem_we;
    logic [PTR_BITS-1:0]           slot_inc;
    logic [SAMPLE_BITS-1:0]        rd_data;
    logic                          hit_next;

    assign commit   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || commit;
    assign accept   = in_valid && in_ready;
    assign mem_we   = commit && !fill_pending_reg;
    assign slot_inc = (slot_reg == LAST_SLOT) ? '0 : slot_reg + PTR_BITS'(1);

    // The read for the incoming word targets the slot left after the word now committing.
    assign slot_next = !commit ? slot_reg : (fill_pending_reg ? '0 : slot_inc);
    assign hit_next  = mem_we && (slot_reg == slot_next);

    mafilt_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot_reg),
        .wdata (s1_sample_reg),
        .re    (accept),
        .raddr (slot_next),
        .rdata (rd_data)
    );

    always_comb
    begin
        logic signed [SAMPLE_BITS-1:0] old_val;
        logic signed [SUM_BITS-1:0]    old_ext;
        logic signed [SUM_BITS-1:0]    new_ext;

        // Before the first wrap the oldest slot still holds the fill word.
        if (!wrapped_reg)
        begin
            old_val = seed_reg;
        end
        else if (s1_hit_reg)
        begin
            old_val = s1_fwd_reg;
        end
        else
        begin
            old_val = signed'(rd_data);
        end
        old_ext = SUM_BITS'(old_val);
        new_ext = SUM_BITS'(s1_sample_reg);
        if (fill_pending_reg)
        begin
            sum_next = new_ext * DEPTH_W;
        end
        else
        begin
            sum_next = sum_reg - old_ext + new_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            fill_pending_reg <= 1'b1;
            wrapped_reg      <= 1'b0;
            slot_reg         <= '0;
            sum_reg          <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (commit)
            begin
                sum_reg          <= sum_next;
                slot_reg         <= slot_next;
                fill_pending_reg <= 1'b0;
                if (!fill_pending_reg && (slot_reg == LAST_SLOT))
                begin
                    wrapped_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= in_sample;
            s1_hit_reg    <= hit_next;
            s1_fwd_reg    <= s1_sample_reg;
        end
        if (commit)
        begin
            out_sum_reg <= sum_next;
            if (fill_pending_reg)
            begin
                seed_reg <= s1_sample_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;

endmodule

// ----- hdl/mafilt_div.sv -----
// Divider by the constant window depth, truncating toward zero, via a reciprocal multiply.
// Three registered stages: magnitude, partial products, recombine and sign.
// Depends on mafilt_pkg.
module mafilt_div #(
    parameter int DEPTH       = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                                        clk,
    input  logic                                                        rst_n,
    input  logic                                                        in_valid,
    output logic                                                        in_ready,
    input  logic signed [mafilt_pkg::sum_width(DEPTH, SAMPLE_BITS)-1:0] in_sum,
    output logic                                                        out_valid,
    input  logic                                                        out_ready,
    output logic signed [SAMPLE_BITS-1:0]                               out_average
);

    localparam int SUM_BITS = mafilt_pkg::sum_width(DEPTH, SAMPLE_BITS);
    localparam int CB       = mafilt_pkg::CHUNK_BITS;
    localparam int SHIFT    = SUM_BITS + $clog2(DEPTH);
    localparam int RW       = SUM_BITS + 1;
    localparam int CHUNKS   = (SUM_BITS + CB - 1) / CB;
    localparam int MW       = CHUNKS * CB;
    localparam int PPW      = CB + RW;
    localparam int TW       = MW + RW;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_FULL);

    logic                 a_valid_reg;
    logic [SUM_BITS-1:0]  a_mag_reg;
    logic                 a_neg_reg;
    logic                 b_valid_reg;
    logic [PPW-1:0]       b_pp_reg [CHUNKS];
    logic                 b_neg_reg;
    logic                 c_valid_reg;
    logic signed [SAMPLE_BITS-1:0] c_average_reg;
    logic signed [SAMPLE_BITS-1:0] average_next;

    logic                 en_a;
    logic                 en_b;
    logic                 en_c;
    logic [MW-1:0]        mag_pad;

    assign en_c     = !c_valid_reg || out_ready;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;
    assign mag_pad  = MW'(a_mag_reg);

    always_comb
    begin
        logic [TW-1:0]          total;
        logic [SAMPLE_BITS-1:0] quot;

        total = '0;
        for (int c = 0; c < CHUNKS; c++)
        begin
            total = total + (TW'(b_pp_reg[c]) << (c * CB));
        end
        quot = total[SHIFT +: SAMPLE_BITS];
        average_next = b_neg_reg ? signed'(-quot) : signed'(quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_neg_reg <= in_sum[SUM_BITS-1];
            a_mag_reg <= in_sum[SUM_BITS-1] ? SUM_BITS'(-in_sum) : SUM_BITS'(in_sum);
        end
        if (en_b)
        begin
            b_neg_reg <= a_neg_reg;
            for (int c = 0; c < CHUNKS; c++)
            begin
                b_pp_reg[c] <= PPW'(mag_pad[c * CB +: CB]) * PPW'(RECIP);
            end
        end
        if (en_c)
        begin
            c_average_reg <= average_next;
        end
    end

    assign out_valid   = c_valid_reg;
    assign out_average = c_average_reg;

endmodule

// ----- hdl/moving_average_filter_core.sv -----
// Top level of the boxcar moving average filter.
// Depends on mafilt_pkg, mafilt_if, mafilt_window and mafilt_div.
//
// Usage
//   Words enter on the samples channel and leave on the averages channel; both are
//   valid/ready streams and a word moves at a rising edge where valid and ready are high.
//   Each sample word yields exactly one average word: the sum of the last DEPTH
//   samples divided by DEPTH, truncated toward zero.
//   The window is a ring of DEPTH samples in a single RAM with registered read data.
//   The read of the oldest slot is issued as a word is accepted; the commit of that word
//   subtracts it from the running sum, adds the new sample and writes the sample back.
//   When the next read hits the slot being written in the same cycle (only possible
//   for a one-entry ring) the written sample is forwarded instead of the RAM data.
//   Throughput is one word per cycle while the receiver holds ready high; an accepted
//   word passes the ring update and three divider stages (magnitude, reciprocal partial
//   products, then recombine and sign) before its average word is valid.
//   After reset the first sample is taken as if the whole ring held it. No RAM clear
//   is needed: until the pointer first wraps, the oldest value comes from a register
//   holding that first sample, so the block accepts words from the first cycle.
//   If the receiver holds ready low, words collect in the pipeline registers; the
//   samples channel keeps accepting until every stage is full, and then its ready drops.
module moving_average_filter_core #(
    parameter int DEPTH       = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    mafilt_sample_if.sink      samples,
    mafilt_average_if.source   averages
);

    localparam int SUM_BITS = mafilt_pkg::sum_width(DEPTH, SAMPLE_BITS);

    // Window sum handed from the ring update to the divider.
    logic                       sum_valid;
    logic                       sum_ready;
    logic signed [SUM_BITS-1:0] sum_word;

    mafilt_window #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .in_sample (samples.sample),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_sum   (sum_word)
    );

    // Constant-depth divide, truncating toward zero; its last stage is the output register.
    mafilt_div #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (sum_valid),
        .in_ready    (sum_ready),
        .in_sum      (sum_word),
        .out_valid   (averages.valid),
        .out_ready   (averages.ready),
        .out_average (averages.average)
    );

endmodule

// ----- dv/moving_average_filter_core_test.sv -----
// Self-checking testbench for the boxcar moving average filter core.
// Depends on the filter RTL and its stream interfaces mafilt_sample_if and mafilt_average_if.
module moving_average_filter_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 8;
    localparam int SAMPLE_BITS  = 16;
    localparam int SUM_BITS     = SAMPLE_BITS + $clog2(DEPTH);
    localparam int SLOT_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RANDOM_WORDS = 1825;
    // Random words in this index range are sent with no idling while the receiver never stalls.
    localparam int STEADY_FIRST = 700;
    localparam int STEADY_LAST  = 1100;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_PERCENT = 14;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // One row of the directed table. Where "typed" is set the expected average is
    // written in by hand; otherwise it is taken from the window predictor.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          typed;
        logic signed [SAMPLE_BITS-1:0] average;
    } directed_row_t;

    localparam int DIRECTED_WORDS = 25;
    localparam directed_row_t DIRECTED_TABLE [DIRECTED_WORDS] = '{
        // The first word after reset fills the whole ring, so its average is itself.
        '{-16'sd32768, 1'b1, -16'sd32768},
        // Walk the window from the negative extreme to the positive one.
        '{16'sd32767, 1'b0, 16'sd0},
        '{16'sd32767, 1'b0, 16'sd0},
        '{16'sd32767, 1'b0, 16'sd0},
        '{16'sd32767, 1'b0, 16'sd0},
        '{16'sd32767, 1'b0, 16'sd0},
        '{16'sd32767, 1'b0, 16'sd0},
        '{16'sd32767, 1'b0, 16'sd0},
        // The ring now holds nothing but the positive extreme.
        '{16'sd32767, 1'b1, 16'sd32767},
        // And back down again to the negative extreme.
        '{-16'sd32768, 1'b0, 16'sd0},
        '{-16'sd32768, 1'b0, 16'sd0},
        '{-16'sd32768, 1'b0, 16'sd0},
        '{-16'sd32768, 1'b0, 16'sd0},
        '{-16'sd32768, 1'b0, 16'sd0},
        '{-16'sd32768, 1'b0, 16'sd0},
        '{-16'sd32768, 1'b0, 16'sd0},
        '{-16'sd32768, 1'b1, -16'sd32768},
        // Small values near zero, with negative averages that exercise truncation toward zero.
        '{16'sd0, 1'b0, 16'sd0},
        '{-16'sd1, 1'b0, 16'sd0},
        '{16'sd1, 1'b0, 16'sd0},
        '{16'sd7, 1'b0, 16'sd0},
        '{-16'sd7, 1'b0, 16'sd0},
        // Alternating bit patterns so that every sample bit is seen at both levels.
        '{16'sh5555, 1'b0, 16'sd0},
        '{16'shAAAA, 1'b0, 16'sd0},
        '{16'sd0, 1'b0, 16'sd0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mafilt_sample_if  #(.SAMPLE_BITS(SAMPLE_BITS)) samples_ch ();
    mafilt_average_if #(.SAMPLE_BITS(SAMPLE_BITS)) averages_ch ();

    moving_average_filter_core #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples_ch),
        .averages (averages_ch)
    );

    // 4 ns clock period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Private copy of the filter state, kept in step with every accepted sample word.
    sample_t                     window_ring [DEPTH];
    logic signed [SUM_BITS-1:0]  window_total;
    logic [SLOT_BITS-1:0]        oldest_idx;
    logic                        ring_unfilled;

    // Averages still owed by the block, oldest first.
    sample_t pending_averages [$];

    int  words_sent;
    int  averages_checked;
    int  failures;
    bit  steady;

    // Folds one accepted sample into the window and returns the average that the
    // block must produce for it. The first sample after reset stands for the whole ring.
    function automatic sample_t advance_window(input sample_t s);
        int total;
        if (ring_unfilled)
        begin
            for (int i = 0; i < DEPTH; i++)
                window_ring[i] = s;
            window_total  = SUM_BITS'(SUM_BITS'(s) * DEPTH);
            oldest_idx    = '0;
            ring_unfilled = 1'b0;
        end
        else
        begin
            window_total = window_total - window_ring[oldest_idx] + s;
            window_ring[oldest_idx] = s;
            oldest_idx = (int'(oldest_idx) == DEPTH - 1) ? '0 : oldest_idx + 1'b1;
        end
        // Integer division in SystemVerilog truncates toward zero, as the block must.
        total = window_total;
        return sample_t'(total / DEPTH);
    endfunction

    // Random sample with a bias toward the extremes, small values around zero and
    // runs of one repeated value, on top of uniformly drawn words.
    function automatic sample_t pick_sample(input sample_t prev);
        int mode;
        mode = $urandom_range(99);
        if (mode < 35)
            return sample_t'($urandom);
        else if (mode < 55)
        begin
            case ($urandom_range(3))
                0: return -16'sd32768;
                1: return 16'sd32767;
                2: return -16'sd1;
                default: return 16'sd0;
            endcase
        end
        else if (mode < 80)
            return sample_t'(int'($urandom_range(32)) - 16);
        else
            return prev;
    endfunction

    // Offers one sample word, with random idle cycles in front of it, and waits until
    // the block takes it. The expected average is queued at the accepting edge.
    task automatic send_word(input sample_t s, input logic typed, input sample_t typed_avg);
        sample_t predicted;
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            samples_ch.valid <= 1'b0;
            @(posedge clk);
        end
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= s;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        predicted = advance_window(s);
        pending_averages.push_back(typed ? typed_avg : predicted);
        words_sent++;
    endtask

    // Receiving side: checks each accepted average word against the oldest
    // expectation and stalls at random, except during the steady stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            averages_ch.ready <= 1'b0;
        end
        else
        begin
            if (averages_ch.valid && averages_ch.ready)
            begin
                if (pending_averages.size() == 0)
                begin
                    $error("average word %0d arrived with none expected",
                           averages_ch.average);
                    failures++;
                end
                else
                begin
                    sample_t wanted;
                    wanted = pending_averages.pop_front();
                    if (averages_ch.average !== wanted)
                    begin
                        $error("average mismatch: expected %0d, actual %0d",
                               wanted, averages_ch.average);
                        failures++;
                    end
                    averages_checked++;
                end
            end
            averages_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Main stimulus: reset, directed table, then the random stream, then drain.
    initial
    begin
        sample_t last;
        samples_ch.valid  = 1'b0;
        samples_ch.sample = '0;
        window_total      = '0;
        oldest_idx        = '0;
        ring_unfilled     = 1'b1;
        words_sent        = 0;
        averages_checked  = 0;
        failures          = 0;
        steady            = 1'b0;
        last              = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_WORDS; i++)
            send_word(DIRECTED_TABLE[i].sample, DIRECTED_TABLE[i].typed,
                      DIRECTED_TABLE[i].average);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            steady = (i >= STEADY_FIRST) && (i <= STEADY_LAST);
            last = pick_sample(last);
            send_word(last, 1'b0, '0);
        end
        steady = 1'b0;
        samples_ch.valid <= 1'b0;

        // Every average must come back; the watchdog catches a block that hangs here.
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d sample words (%0d from the directed table, %0d random)",
                 words_sent, DIRECTED_WORDS, RANDOM_WORDS);
        $display("and compared %0d average words with the window predictor.",
                 averages_checked);
        if (failures == 0)
            $display("moving_average_filter_core_test OK");
        else
            $display("moving_average_filter_core_test NOT OK");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run of a few tens of microseconds.
    initial
    begin
        #2_000_000;
        $display("moving_average_filter_core_test NOT OK");
        $finish;
    end

endmodule
